// ===== src/button_debounce_select_counter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce select counter
// Concurrent assertion wrappers. These compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_SELECT_COUNTER_MACROS_SVH
`define BUTTON_DEBOUNCE_SELECT_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is high
`define BDSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also checked during reset
`define BDSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BDSC_ASSERT(label, clk, rst, prop, msg)
`define BDSC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== src/bdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdsc_pkg
// Types and constants shared by the button debounce select counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdsc_pkg;

   // Item kinds
   localparam logic KIND_PRESS = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // Button codes
   localparam logic [1:0] BTN_NONE  = 2'd0;
   localparam logic [1:0] BTN_LEFT  = 2'd1;
   localparam logic [1:0] BTN_RIGHT = 2'd2;
   localparam logic [1:0] BTN_BAD   = 2'd3;

   // Phase codes as they appear on the result
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_PRESS   = 2'd1;
   localparam logic [1:0] PHASE_MONITOR = 2'd2;
   localparam logic [1:0] PHASE_RELEASE = 2'd3;

   // Configuration register indexes
   localparam logic CSR_PRESS_DELAY   = 1'b0;
   localparam logic CSR_RELEASE_DELAY = 1'b1;

   // Delay widths and reset values
   localparam int unsigned DELAY_W = 8;
   localparam logic [DELAY_W-1:0] PRESS_DELAY_RST   = 8'd5;
   localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST = 8'd15;

   // Chosen value when nothing has been committed
   localparam logic [3:0] CHOSEN_NONE = 4'hF;

   // Debounce phases, one-hot
   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_PRESS   = 4'b0010,
      ST_MONITOR = 4'b0100,
      ST_RELEASE = 4'b1000
   } phase_type;

   // Input transaction
   typedef struct packed {
      logic       kind;
      logic [1:0] button;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [1:0]        phase;
      logic signed [3:0] chosen;
      logic [1:0]        pressed_button;
      logic [2:0]        left_count;
      logic [2:0]        right_count;
      logic              committed;
   } rsp_type;

   // One-hot phase to its result code
   function automatic logic [1:0] phase_code(input phase_type st);
      logic [1:0] code;
      unique case (st)
         ST_IDLE:    code = PHASE_IDLE;
         ST_PRESS:   code = PHASE_PRESS;
         ST_MONITOR: code = PHASE_MONITOR;
         ST_RELEASE: code = PHASE_RELEASE;
         default:    code = PHASE_IDLE;
      endcase
      return code;
   endfunction

endpackage

// ===== src/bdsc_core.sv =====
// ----------------------------------------------------------------------------
// bdsc_core
// Debounce state machine and select counters. Updates its state on each
// step and presents the result for that transaction combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_debounce_select_counter_macros.svh"

module bdsc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  bdsc_pkg::req_type             item,
   input  logic [bdsc_pkg::DELAY_W-1:0]  press_delay,
   input  logic [bdsc_pkg::DELAY_W-1:0]  release_delay,
   output bdsc_pkg::rsp_type             result
);
   import bdsc_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [DELAY_W-1:0] countdown_ff, countdown_in;
   logic [DELAY_W-1:0] count_dec;
   logic [1:0]         stored_ff, stored_in;
   logic [2:0]         left_ff, left_in;
   logic [2:0]         right_ff, right_in;
   logic [3:0]         chosen_ff, chosen_in;
   logic               press_done_ff, press_done_in;
   logic               release_done_ff, release_done_in;
   logic               committed;

   // Countdown decrement, saturating at zero
   assign count_dec = (countdown_ff != '0) ? countdown_ff - 1'b1 : '0;

   // Next state for one transaction
   always_comb begin
      phase_in        = phase_ff;
      countdown_in    = countdown_ff;
      stored_in       = stored_ff;
      left_in         = left_ff;
      right_in        = right_ff;
      chosen_in       = chosen_ff;
      press_done_in   = press_done_ff;
      release_done_in = release_done_ff;
      committed       = 1'b0;

      if (item.kind == KIND_PRESS) begin
         // press only starts a cycle from idle
         if (phase_ff == ST_IDLE) begin
            stored_in       = (item.button == BTN_BAD) ? BTN_NONE : item.button;
            press_done_in   = 1'b0;
            release_done_in = 1'b0;
            chosen_in       = CHOSEN_NONE;
            countdown_in    = press_delay;
            phase_in        = ST_PRESS;
         end
      end else begin
         countdown_in = count_dec;
         unique case (phase_ff)
            ST_PRESS: begin
               if (count_dec == '0) begin
                  press_done_in = 1'b1;
                  phase_in      = ST_MONITOR;
               end
            end
            ST_MONITOR: begin
               if (item.button == BTN_NONE) begin
                  phase_in     = ST_RELEASE;
                  countdown_in = release_delay;
               end
            end
            ST_RELEASE: begin
               if (count_dec == '0) begin
                  release_done_in = 1'b1;
                  phase_in        = ST_IDLE;
                  committed       = 1'b1;
                  if (stored_ff == BTN_LEFT) begin
                     left_in   = left_ff + 3'd1;
                     chosen_in = {1'b0, left_in};
                  end else if (stored_ff == BTN_RIGHT) begin
                     right_in  = right_ff + 3'd1;
                     chosen_in = {1'b0, right_in};
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ST_IDLE;
         countdown_ff    <= '0;
         stored_ff       <= BTN_NONE;
         left_ff         <= '0;
         right_ff        <= '0;
         chosen_ff       <= CHOSEN_NONE;
         press_done_ff   <= 1'b0;
         release_done_ff <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         countdown_ff    <= countdown_in;
         stored_ff       <= stored_in;
         left_ff         <= left_in;
         right_ff        <= right_in;
         chosen_ff       <= chosen_in;
         press_done_ff   <= press_done_in;
         release_done_ff <= release_done_in;
      end
   end

   // Result after the update
   always_comb begin
      result.phase          = phase_code(phase_in);
      result.chosen         = (press_done_in && release_done_in) ?
                              $signed(chosen_in) : $signed(CHOSEN_NONE);
      result.pressed_button = stored_in;
      result.left_count     = left_in;
      result.right_count    = right_in;
      result.committed      = committed;
   end

   `BDSC_ASSERT(a_commit_from_release, clock, reset, step && committed |-> phase_ff == ST_RELEASE && item.kind == KIND_TICK, "commit outside release delay")
   `BDSC_ASSERT(a_left_advance, clock, reset, step && committed && stored_ff == BTN_LEFT |=> left_ff == 3'($past(left_ff) + 3'd1), "left counter did not advance on commit")
   `BDSC_ASSERT(a_hold_without_step, clock, reset, !step |=> $stable(phase_ff) && $stable(countdown_ff) && $stable(chosen_ff), "state changed without a transaction")
   `BDSC_ASSERT(a_idle_after_commit, clock, reset, step && committed |=> phase_ff == ST_IDLE && release_done_ff, "commit did not return to idle")

endmodule

// ===== src/button_debounce_select_counter.sv =====
// ----------------------------------------------------------------------------
// button_debounce_select_counter
// Two-button debounce with a select counter per button, behind an input
// register and a result register.
//
//   channel   direction  handshake                  payload
//   req_      in         req_valid / req_stall      req_data  (kind, button)
//   rsp_      out        rsp_valid / rsp_stall      rsp_data  (phase ... committed)
//   csr_      in         csr_write                  csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_stall is low; each passes through
// the input register and then the result register.
// The debounce state updates as a transaction moves from input to result.
// Reset is synchronous and restores the delays to 5 and 15 ticks.
// req_stall rises only when both registers are full and rsp_stall is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_debounce_select_counter_macros.svh"

module button_debounce_select_counter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bdsc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bdsc_pkg::rsp_type             rsp_data,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [bdsc_pkg::DELAY_W-1:0]  csr_wdata
);
   import bdsc_pkg::*;

   logic [DELAY_W-1:0] press_delay_ff, release_delay_ff;
   req_type            req_ff;
   logic               in_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            result;
   logic               out_valid_ff;
   logic               req_accept;
   logic               move;

   // Handshake
   assign move       = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = rsp_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         press_delay_ff   <= PRESS_DELAY_RST;
         release_delay_ff <= RELEASE_DELAY_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PRESS_DELAY:   press_delay_ff   <= csr_wdata;
            CSR_RELEASE_DELAY: release_delay_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
   end

   bdsc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (move),
      .item          (req_ff),
      .press_delay   (press_delay_ff),
      .release_delay (release_delay_ff),
      .result        (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_ff <= result;
      end
   end

   `BDSC_ASSERT(a_move_fills_output, clock, reset, move |=> rsp_valid, "moved transaction did not reach the result register")
   `BDSC_ASSERT(a_stall_means_full, clock, reset, req_stall |-> in_valid_ff && !move, "input stalled with room to advance")
   `BDSC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !in_valid_ff, "pipeline not empty after reset")

endmodule
